>>> sv/hwt_pkg.sv
// hwt_pkg: shared constants and types of the hashed timing wheel
// field widths, item codes, entry layout and parameter defaults
// no dependencies
`default_nettype none

package hwt_pkg;

    localparam int DEF_WHEEL_SLOTS = 10;
    localparam int DEF_TICK_MS     = 10;
    localparam int DEF_MAX_TIMERS  = 64;

    localparam int DELAY_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int ROUNDS_W = 26;
    localparam int HANDLE_W = 6;
    localparam int KIND_W   = 2;

    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = {ROUNDS_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONCE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVERY = 2'd2;

    localparam logic [KIND_W-1:0] RES_STARTED = 2'd0;
    localparam logic [KIND_W-1:0] RES_FIRED   = 2'd1;
    localparam logic [KIND_W-1:0] RES_FULL    = 2'd2;

    // period is kept as its quotient and slot offset, worked out at start
    typedef struct packed {
        logic                periodic;
        logic [ROUNDS_W-1:0] per_rounds;
        logic [SLOT_W-1:0]   per_off;
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
    } t_entry;

endpackage

`default_nettype wire

>>> sv/hashed_timing_wheel.sv
// hashed_timing_wheel: timer table in one synchronous memory, sequential scan
// uses hwt_pkg for codes, widths and the entry layout
`default_nettype none

// Hashed timing wheel with WHEEL_SLOTS slots of TICK_MS ms and MAX_TIMERS
// entries. A start item (tuser 1 one-shot, 2 periodic, tdata delay in ms)
// finds the lowest free entry by walking the valid bits one per cycle, then
// splits the delay by a reciprocal multiply and writes the entry; it gives
// one result (started or full). A tick item (tuser 0) walks the table:
// each valid entry is read through the memory's registered read port and
// then processed, free entries are skipped; each firing entry gives one
// result, the final one flagged by tlast. Periodic entries are rescheduled
// without a divide, as their period is stored already split. Kind 3 is
// taken and ignored. Input is taken only while no item is in work; a result
// waits in the output register, and the next item is taken meanwhile but
// stalls before giving a result of its own until the waiting one is taken.
module hashed_timing_wheel
    import hwt_pkg::*;
#(
    parameter int WHEEL_SLOTS = DEF_WHEEL_SLOTS,
    parameter int TICK_MS     = DEF_TICK_MS,
    parameter int MAX_TIMERS  = DEF_MAX_TIMERS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // delay_ms
    input  wire  [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // handle, zero fill
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    localparam int ROUND_MS = WHEEL_SLOTS * TICK_MS;
    localparam int RW       = $clog2(ROUND_MS);
    localparam int IW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_TIMERS - 1);

    // reciprocal of the round length, exact for every 32-bit delay
    localparam int MUL_S = DELAY_W + RW;
    localparam logic [32:0] RECIP =
        33'(((64'd1 << MUL_S) + 64'(ROUND_MS) - 64'd1) / 64'(ROUND_MS));
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIND = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_OFF  = 4'd3;
    localparam logic [3:0] S_FULL = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_PROC = 4'd6;
    localparam logic [3:0] S_TEND = 4'd7;

    t_entry r_mem [MAX_TIMERS];
    t_entry r_rd;

    logic [3:0]            r_state,      n_state;
    logic [IW-1:0]         r_idx,        n_idx;
    logic [SLOT_W-1:0]     r_cur,        n_cur;
    logic                  r_every,      n_every;
    logic [DELAY_W-1:0]    r_dividend,   n_dividend;
    logic [DELAY_W-1:0]    r_quot,       n_quot;
    logic [RW-1:0]         r_rem,        n_rem;
    logic [4:0]            r_cnt,        n_cnt;
    logic [47:0]           r_prod_lo,    n_prod_lo;
    logic [48:0]           r_prod_hi,    n_prod_hi;
    logic [MAX_TIMERS-1:0] r_valid,      n_valid;
    logic                  r_pend_valid, n_pend_valid;
    logic [IW-1:0]         r_pend_idx,   n_pend_idx;
    logic                  r_out_valid,  n_out_valid;
    logic [KIND_W-1:0]     r_out_kind,   n_out_kind;
    logic [HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic                  r_out_last,   n_out_last;

    logic                  mem_we;
    logic                  mem_re;
    t_entry                mem_wdata;
    logic                  out_free;
    logic [64:0]           mul_sum;
    logic [15:0]           off_rem;
    logic [SLOT_W-1:0]     off_val;
    logic [ROUNDS_W-1:0]   q_sat;
    logic [ROUNDS_W-1:0]   re_rounds;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] a,
                                                    input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(WHEEL_SLOTS)) begin
            s = s - (SLOT_W+1)'(WHEEL_SLOTS);
        end
        return s[SLOT_W-1:0];
    endfunction

    assign out_free = !r_out_valid || m_tready;
    assign s_tready = i_rst_n && (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tdata  = {2'b00, r_out_handle};
    assign m_tlast  = r_out_last;

    // delay times reciprocal, from two partial products
    assign mul_sum = {r_prod_hi, 16'b0} + {17'b0, r_prod_lo};

    assign q_sat = (|r_quot[DELAY_W-1:ROUNDS_W]) ? ROUNDS_MAX : r_quot[ROUNDS_W-1:0];

    // slot offset of the remainder, at most four compare-subtract steps
    always_comb begin
        off_rem = 16'(r_rem);
        off_val = '0;
        for (int k = SLOT_W - 1; k >= 0; k--) begin
            if (off_rem >= 16'(TICK_MS << k)) begin
                off_rem    = off_rem - 16'(TICK_MS << k);
                off_val[k] = 1'b1;
            end
        end
    end

    assign re_rounds = r_rd.per_rounds -
        ROUNDS_W'((r_rd.per_off == '0) && (r_rd.per_rounds != '0));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_every      = r_every;
        n_dividend   = r_dividend;
        n_quot       = r_quot;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_prod_lo    = r_prod_lo;
        n_prod_hi    = r_prod_hi;
        n_valid      = r_valid;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_kind   = r_out_kind;
        n_out_handle = r_out_handle;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_idx = '0;
                    case (s_tuser) inside
                        KIND_TICK: begin
                            n_pend_valid = 1'b0;
                            n_state      = S_RD;
                        end
                        KIND_ONCE, KIND_EVERY: begin
                            n_every = (s_tuser == KIND_EVERY);
                            if ((s_tuser == KIND_EVERY) && (s_tdata < DELAY_W'(TICK_MS))) begin
                                n_dividend = DELAY_W'(TICK_MS);
                            end else begin
                                n_dividend = s_tdata;
                            end
                            n_state = S_FIND;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIND: begin
                if (!r_valid[r_idx]) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_FULL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    5'd0: n_prod_lo = 48'(r_dividend) * 48'(RECIP_LO);
                    5'd1: n_prod_hi = 49'(r_dividend) * 49'(RECIP_HI);
                    5'd2: n_quot = DELAY_W'(mul_sum >> MUL_S);
                    5'd3: n_prod_lo = 48'(r_quot) * 48'(ROUND_MS);
                    default: begin
                        n_rem   = RW'(r_dividend - r_prod_lo[DELAY_W-1:0]);
                        n_state = S_OFF;
                    end
                endcase
            end
            S_OFF: begin
                if (out_free) begin
                    mem_we               = 1'b1;
                    mem_wdata.periodic   = r_every;
                    mem_wdata.per_rounds = q_sat;
                    mem_wdata.per_off    = off_val;
                    mem_wdata.slot       = wrap_slot(r_cur, off_val);
                    mem_wdata.rounds     = q_sat;
                    n_valid[r_idx]       = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out_kind           = RES_STARTED;
                    n_out_handle         = HANDLE_W'(r_idx);
                    n_out_last           = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_FULL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = RES_FULL;
                    n_out_handle = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                if (r_valid[r_idx]) begin
                    mem_re  = 1'b1;
                    n_state = S_PROC;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_TEND;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PROC: begin
                if ((r_rd.slot != r_cur) || (r_rd.rounds != '0) ||
                    !r_pend_valid || out_free) begin
                    if (r_rd.slot == r_cur) begin
                        if (r_rd.rounds != '0) begin
                            mem_we           = 1'b1;
                            mem_wdata.rounds = r_rd.rounds - 1'b1;
                        end else begin
                            // fired: the held result goes out, this one is held
                            if (r_pend_valid) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = RES_FIRED;
                                n_out_handle = HANDLE_W'(r_pend_idx);
                                n_out_last   = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_idx   = r_idx;
                            if (r_rd.periodic) begin
                                mem_we           = 1'b1;
                                mem_wdata.slot   = wrap_slot(r_cur, r_rd.per_off);
                                mem_wdata.rounds = re_rounds;
                            end else begin
                                n_valid[r_idx] = 1'b0;
                            end
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = S_TEND;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_TEND: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = RES_FIRED;
                        n_out_handle = HANDLE_W'(r_pend_idx);
                        n_out_last   = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_cur = (r_cur == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : r_cur + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_every      <= n_every;
        r_dividend   <= n_dividend;
        r_quot       <= n_quot;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_prod_lo    <= n_prod_lo;
        r_prod_hi    <= n_prod_hi;
        r_pend_idx   <= n_pend_idx;
        r_out_kind   <= n_out_kind;
        r_out_handle <= n_out_handle;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire
